// ===== hw/rtl/bec_pkg.sv =====
// Package for the backslash escape codec: decode phase type, result and
// burst types, character constants and hex digit helpers.
// No dependencies.
`default_nettype none

package bec_pkg;

  // Most results one input byte can cause (a \xHH escape).
  localparam int unsigned BURST_MAX = 4;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned IDX_W     = 2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_HEX_HI = 2'd2,
    PH_HEX_LO = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
  } res_t;

  typedef struct packed {
    res_t [BURST_MAX-1:0] item;
    logic [CNT_W-1:0]     count;
    logic                 str_end;
  } burst_t;

  // Upper-case hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = wide + 8'h30;
    end else begin
      hex_char = wide + 8'h37;
    end
  endfunction

  // Value of a hex digit of either case; bit 4 set when not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    hex_val = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      hex_val = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      hex_val = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      hex_val = {1'b0, d[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bec_xlat.sv =====
// Translation stage: turns one input byte into a burst of up to four
// results and holds the decoder's escape state. Depends on bec_pkg.
`default_nettype none

module bec_xlat (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          dir,
  input  wire logic [7:0]    in_byte,
  input  wire logic          str_end,
  output bec_pkg::burst_t    burst
);
  import bec_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       swallowing, swallowing_next;

  res_t       ok_res;
  logic [4:0] hv;
  logic       err;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      high_nibble <= 4'h0;
      swallowing  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      swallowing  <= swallowing_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    swallowing_next  = swallowing;
    burst            = '0;
    burst.str_end    = str_end;
    ok_res           = '{out_byte: 8'h00, byte_valid: 1'b1, status: STATUS_OK};
    hv               = hex_val(in_byte);
    err              = 1'b0;

    if (dir == DIR_ENCODE) begin
      burst.item[0] = '{out_byte: CH_BSLASH, byte_valid: 1'b1, status: STATUS_OK};
      burst.item[1] = '{out_byte: CH_BSLASH, byte_valid: 1'b1, status: STATUS_OK};
      burst.item[2] = '{out_byte: hex_char(in_byte[7:4]), byte_valid: 1'b1,
                        status: STATUS_OK};
      burst.item[3] = '{out_byte: hex_char(in_byte[3:0]), byte_valid: 1'b1,
                        status: STATUS_OK};
      burst.count   = 3'd2;
      priority if (in_byte == CH_BSLASH) begin
        burst.item[1].out_byte = CH_BSLASH;
      end else if (in_byte == CH_LF) begin
        burst.item[1].out_byte = CH_N;
      end else if (in_byte == CH_CR) begin
        burst.item[1].out_byte = CH_R;
      end else if (in_byte == CH_TAB) begin
        burst.item[1].out_byte = CH_T;
      end else if (in_byte < CH_SPACE || in_byte == CH_DEL) begin
        burst.item[1].out_byte = CH_X;
        burst.count            = 3'd4;
      end else begin
        burst.item[0].out_byte = in_byte;
        burst.count            = 3'd1;
      end
    end else if (swallowing) begin
      // The error was already reported; only the string end shows up.
      if (str_end) begin
        burst.count = 3'd1;
      end
    end else begin
      unique case (phase)
        PH_NORMAL: begin
          if (in_byte != CH_BSLASH) begin
            ok_res.out_byte = in_byte;
            burst.item[0]   = ok_res;
            burst.count     = 3'd1;
          end else if (str_end) begin
            err = 1'b1;
          end else begin
            phase_next = PH_ESC;
          end
        end
        PH_ESC: begin
          phase_next = PH_NORMAL;
          burst.count = 3'd1;
          priority if (in_byte == CH_BSLASH) begin
            ok_res.out_byte = CH_BSLASH;
          end else if (in_byte == CH_N) begin
            ok_res.out_byte = CH_LF;
          end else if (in_byte == CH_R) begin
            ok_res.out_byte = CH_CR;
          end else if (in_byte == CH_T) begin
            ok_res.out_byte = CH_TAB;
          end else if (in_byte == CH_X && !str_end) begin
            phase_next  = PH_HEX_HI;
            burst.count = 3'd0;
          end else begin
            err = 1'b1;
          end
          burst.item[0] = ok_res;
        end
        PH_HEX_HI: begin
          if (hv[4] || str_end) begin
            err = 1'b1;
          end else begin
            high_nibble_next = hv[3:0];
            phase_next       = PH_HEX_LO;
          end
        end
        PH_HEX_LO: begin
          phase_next = PH_NORMAL;
          if (hv[4]) begin
            err = 1'b1;
          end else begin
            ok_res.out_byte = {high_nibble, hv[3:0]};
            burst.item[0]   = ok_res;
            burst.count     = 3'd1;
          end
        end
        default: begin
          phase_next = PH_NORMAL;
        end
      endcase

      if (err) begin
        phase_next    = PH_NORMAL;
        swallowing_next = 1'b1;
        burst.item[0] = '{out_byte: 8'h00, byte_valid: 1'b0, status: STATUS_ERR};
        burst.count   = 3'd1;
      end
    end

    // Every string end leaves the decoder clean, in either direction.
    if (str_end) begin
      phase_next       = PH_NORMAL;
      high_nibble_next = 4'h0;
      swallowing_next  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bec_burst.sv =====
// Result register: holds one burst and hands its results out one per
// cycle under the output stall. Depends on bec_pkg.
`default_nettype none

module bec_burst (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire bec_pkg::burst_t  burst_in,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  byte_valid,
  output logic                  run_last,
  output logic                  status,
  output logic                  string_done
);
  import bec_pkg::*;

  burst_t           burst;
  logic [IDX_W-1:0] idx;
  logic             taken;
  res_t             cur;

  assign cur         = burst.item[idx];
  assign run_last    = ({1'b0, idx} == burst.count - 3'd1);
  assign out_byte    = cur.out_byte;
  assign byte_valid  = cur.byte_valid;
  assign status      = cur.status;
  assign string_done = run_last & burst.str_end;

  assign taken = out_valid & ~out_stall;
  // A new burst may enter when the register is empty or its last result
  // leaves in this cycle.
  assign free  = ~out_valid | (taken & run_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (taken) begin
      if (run_last) begin
        out_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/backslash_escape_codec.sv =====
// Top level of the backslash escape codec: input register, translation
// stage and result register. Depends on bec_pkg, bec_xlat and bec_burst.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    in_byte, content_end
//   out      from block out_valid / out_stall  out_byte, byte_valid, run_last,
//                                              status, string_done
//   cfg      to block   cfg_valid / cfg_ready  direction
//
// An input byte waits in the input register, then is translated and
// loaded into the result register, which gives one result per cycle
// while out_stall is low. Encoding gives one result for plain bytes, two for
// short escapes and four for \xHH. Bytes that cause no result load nothing.
// Reset is synchronous and clears the decoder state, direction and all valids.
// A stalled output holds the burst; the input stalls once its register is full.
`default_nettype none

module backslash_escape_codec (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       content_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            run_last,
  output logic            status,
  output logic            string_done,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       direction
);
  import bec_pkg::*;

  logic       dir;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_end;
  logic       accept;
  logic       move;
  logic       free;
  burst_t     burst;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= DIR_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      dir <= direction;
    end
  end

  assign move     = hold_valid & free;
  assign in_stall = hold_valid & ~move;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= in_byte;
      hold_end  <= content_end;
    end
  end

  bec_xlat u_xlat (
    .clk     (clk),
    .rst     (rst),
    .step    (move),
    .dir     (dir),
    .in_byte (hold_byte),
    .str_end (hold_end),
    .burst   (burst)
  );

  bec_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .load        (move && (burst.count != 3'd0)),
    .burst_in    (burst),
    .free        (free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .run_last    (run_last),
    .status      (status),
    .string_done (string_done)
  );

endmodule

`default_nettype wire

// ===== bench/backslash_escape_codec_test.sv =====
// Testbench for backslash_escape_codec: a table of directed bytes checked against
// listed results, then random encode and decode strings checked against a behavioral codec model.
// Depends on bec_pkg and the codec RTL.

module backslash_escape_codec_test;
  import bec_pkg::*;

  localparam int LIMIT_CYCLES  = 100000;
  localparam int SETTLE_CYCLES = 8;
  localparam int CHUNK_BYTES   = 31;

  typedef enum logic [2:0] {
    CHK_MODEL,
    CHK_BYTES,
    CHK_ERROR,
    CHK_MARK,
    CHK_QUIET
  } chk_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       status;
    logic       string_done;
  } result_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  b;
    logic        fin;
    chk_t        kind;
    logic [2:0]  n;
    logic [31:0] bytes;
  } row_t;

  localparam logic [127:0] HEX_UP = "0123456789ABCDEF";

  localparam logic [7:0] ENC_EDGE [9] = '{CH_BSLASH, CH_LF, CH_CR, CH_TAB, 8'h00, 8'h1F,
                                         CH_DEL, CH_SPACE, 8'hFF};

  // Typed results are listed first byte first in the bytes field.
  localparam row_t PLAN [27] = '{
    '{DIR_ENCODE, 8'h41,     1'b0, CHK_BYTES, 3'd1, {8'h41, 24'h0}},
    '{DIR_ENCODE, CH_BSLASH, 1'b0, CHK_BYTES, 3'd2, {CH_BSLASH, CH_BSLASH, 16'h0}},
    '{DIR_ENCODE, CH_LF,     1'b0, CHK_BYTES, 3'd2, {CH_BSLASH, CH_N, 16'h0}},
    '{DIR_ENCODE, CH_CR,     1'b0, CHK_BYTES, 3'd2, {CH_BSLASH, CH_R, 16'h0}},
    '{DIR_ENCODE, CH_TAB,    1'b0, CHK_BYTES, 3'd2, {CH_BSLASH, CH_T, 16'h0}},
    '{DIR_ENCODE, 8'h00,     1'b0, CHK_BYTES, 3'd4, {CH_BSLASH, CH_X, 8'h30, 8'h30}},
    '{DIR_ENCODE, 8'h1F,     1'b0, CHK_BYTES, 3'd4, {CH_BSLASH, CH_X, 8'h31, 8'h46}},
    '{DIR_ENCODE, CH_DEL,    1'b0, CHK_BYTES, 3'd4, {CH_BSLASH, CH_X, 8'h37, 8'h46}},
    '{DIR_ENCODE, CH_SPACE,  1'b0, CHK_BYTES, 3'd1, {CH_SPACE, 24'h0}},
    '{DIR_ENCODE, 8'hFF,     1'b1, CHK_BYTES, 3'd1, {8'hFF, 24'h0}},
    '{DIR_DECODE, CH_BSLASH, 1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, CH_N,      1'b0, CHK_BYTES, 3'd1, {CH_LF, 24'h0}},
    '{DIR_DECODE, CH_BSLASH, 1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, CH_X,      1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, 8'h61,     1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, 8'h46,     1'b0, CHK_BYTES, 3'd1, {8'hAF, 24'h0}},
    '{DIR_DECODE, CH_BSLASH, 1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, 8'h71,     1'b0, CHK_ERROR, 3'd0, 32'h0},
    '{DIR_DECODE, 8'h41,     1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, 8'h42,     1'b1, CHK_MARK,  3'd0, 32'h0},
    '{DIR_DECODE, CH_BSLASH, 1'b1, CHK_ERROR, 3'd0, 32'h0},
    '{DIR_DECODE, CH_BSLASH, 1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, CH_X,      1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_DECODE, 8'h34,     1'b1, CHK_ERROR, 3'd0, 32'h0},
    // An escape left open while the encoder runs is finished after switching back.
    '{DIR_DECODE, CH_BSLASH, 1'b0, CHK_QUIET, 3'd0, 32'h0},
    '{DIR_ENCODE, 8'h41,     1'b0, CHK_BYTES, 3'd1, {8'h41, 24'h0}},
    '{DIR_DECODE, CH_N,      1'b1, CHK_BYTES, 3'd1, {CH_LF, 24'h0}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       content_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       status;
  logic       string_done;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       direction = DIR_ENCODE;

  // Side information for the request on the input port.
  chk_t        cur_kind = CHK_MODEL;
  logic [2:0]  cur_n = 3'd0;
  logic [31:0] cur_bytes = 32'h0;
  logic        cur_mode = DIR_ENCODE;

  // Codec model state.
  logic        model_dir = DIR_ENCODE;
  phase_t      dec_phase = PH_NORMAL;
  logic [3:0]  held_nib = 4'h0;
  logic        swallow = 1'b0;
  result_t     burst [4];
  int          burst_n;

  result_t     pending_results [$];
  logic [7:0]  text [$];

  int send_idle_pct = 33;
  int stall_pct = 73;
  int sent_bytes = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int fail_count = 0;
  int cycle_count = 0;

  backslash_escape_codec uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .content_end (content_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .run_last    (run_last),
    .status      (status),
    .string_done (string_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .direction   (direction)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Bit 4 is set when the character is not a hex digit.
  function automatic logic [4:0] nib_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic logic [7:0] rand_hex();
    logic [7:0] k;
    k = 8'($urandom_range(15));
    if (k < 8'd10) return 8'h30 + k;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + k - 8'd10;
  endfunction

  task automatic add_result(input logic [7:0] b, input logic v, input logic st);
    burst[burst_n] = '{b, v, 1'b0, st, 1'b0};
    burst_n++;
  endtask

  // Results of one byte, without the run_last and string_done marks.
  task automatic step_codec(input logic [7:0] b, input logic fin);
    logic [4:0] hv;
    logic       bad;
    burst_n = 0;
    bad = 1'b0;
    hv = nib_value(b);
    if (model_dir == DIR_ENCODE) begin
      if (b == CH_BSLASH || b == CH_LF || b == CH_CR || b == CH_TAB) begin
        add_result(CH_BSLASH, 1'b1, STATUS_OK);
        add_result(b == CH_LF ? CH_N : b == CH_CR ? CH_R : b == CH_TAB ? CH_T : CH_BSLASH,
                   1'b1, STATUS_OK);
      end else if (b < CH_SPACE || b == CH_DEL) begin
        add_result(CH_BSLASH, 1'b1, STATUS_OK);
        add_result(CH_X, 1'b1, STATUS_OK);
        add_result(HEX_UP[8 * (15 - b[7:4]) +: 8], 1'b1, STATUS_OK);
        add_result(HEX_UP[8 * (15 - b[3:0]) +: 8], 1'b1, STATUS_OK);
      end else begin
        add_result(b, 1'b1, STATUS_OK);
      end
    end else if (swallow) begin
      // The error was already reported; only the string end is marked.
      if (fin) add_result(8'h00, 1'b0, STATUS_OK);
    end else begin
      case (dec_phase)
        PH_NORMAL: begin
          if (b != CH_BSLASH) add_result(b, 1'b1, STATUS_OK);
          else if (fin) bad = 1'b1;
          else dec_phase = PH_ESC;
        end
        PH_ESC: begin
          dec_phase = PH_NORMAL;
          if (b == CH_BSLASH) add_result(CH_BSLASH, 1'b1, STATUS_OK);
          else if (b == CH_N) add_result(CH_LF, 1'b1, STATUS_OK);
          else if (b == CH_R) add_result(CH_CR, 1'b1, STATUS_OK);
          else if (b == CH_T) add_result(CH_TAB, 1'b1, STATUS_OK);
          else if (b == CH_X && !fin) dec_phase = PH_HEX_HI;
          else bad = 1'b1;
        end
        PH_HEX_HI: begin
          if (hv[4] || fin) begin
            bad = 1'b1;
          end else begin
            held_nib = hv[3:0];
            dec_phase = PH_HEX_LO;
          end
        end
        default: begin
          dec_phase = PH_NORMAL;
          if (hv[4]) bad = 1'b1;
          else add_result({held_nib, hv[3:0]}, 1'b1, STATUS_OK);
        end
      endcase
      if (bad) begin
        dec_phase = PH_NORMAL;
        swallow = 1'b1;
        add_result(8'h00, 1'b0, STATUS_ERR);
      end
    end
    if (fin) begin
      dec_phase = PH_NORMAL;
      held_nib = 4'h0;
      swallow = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("Mismatch at cycle %0d: %s is %0h, expected %0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("unrequested result, out_byte", out_byte, 8'h00);
    end else begin
      want = pending_results.pop_front();
      if (out_byte !== want.out_byte) report_mismatch("out_byte", out_byte, want.out_byte);
      if (byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", {7'h0, byte_valid}, {7'h0, want.byte_valid});
      if (run_last !== want.run_last)
        report_mismatch("run_last", {7'h0, run_last}, {7'h0, want.run_last});
      if (status !== want.status)
        report_mismatch("status", {7'h0, status}, {7'h0, want.status});
      if (string_done !== want.string_done)
        report_mismatch("string_done", {7'h0, string_done}, {7'h0, want.string_done});
    end
  endtask

  task automatic take_request();
    int k;
    step_codec(in_byte, content_end);
    case (cur_kind)
      CHK_BYTES: begin
        burst_n = cur_n;
        for (k = 0; k < 4; k++) burst[k] = '{cur_bytes[31 - 8 * k -: 8], 1'b1, 1'b0,
                                             STATUS_OK, 1'b0};
      end
      CHK_ERROR: begin
        burst_n = 1;
        burst[0] = '{8'h00, 1'b0, 1'b0, STATUS_ERR, 1'b0};
      end
      CHK_MARK: begin
        burst_n = 1;
        burst[0] = '{8'h00, 1'b0, 1'b0, STATUS_OK, 1'b0};
      end
      CHK_QUIET: burst_n = 0;
      default: ;
    endcase
    if (burst_n > 0) begin
      burst[burst_n - 1].run_last = 1'b1;
      burst[burst_n - 1].string_done = content_end;
    end
    for (k = 0; k < burst_n; k++) pending_results.push_back(burst[k]);
  endtask

  // Results are checked before the new request is modeled, so a result can
  // never be matched against the request accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_request();
      if (cfg_valid && cfg_ready) model_dir = direction;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin, input chk_t kind,
                           input logic [2:0] n, input logic [31:0] bytes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    content_end <= fin;
    cur_kind <= kind;
    cur_n <= n;
    cur_bytes <= bytes;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Bytes that are swallowed give no result, so after the expected results drain
  // the task still waits for them to leave the pipeline.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_direction(input logic d);
    wait_quiet();
    cfg_valid <= 1'b1;
    direction <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_mode = d;
    cfg_writes++;
  endtask

  task automatic send_text();
    int k;
    for (k = 0; k < text.size(); k++)
      send_byte(text[k], k == text.size() - 1, CHK_MODEL, 3'd0, 32'h0);
  endtask

  task automatic push_token();
    logic [7:0] c;
    case ($urandom_range(5))
      0: begin
        do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
        text.push_back(c);
      end
      1: begin text.push_back(CH_BSLASH); text.push_back(CH_BSLASH); end
      2: begin text.push_back(CH_BSLASH); text.push_back(CH_N); end
      3: begin text.push_back(CH_BSLASH); text.push_back(CH_R); end
      4: begin text.push_back(CH_BSLASH); text.push_back(CH_T); end
      default: begin
        text.push_back(CH_BSLASH);
        text.push_back(CH_X);
        text.push_back(rand_hex());
        text.push_back(rand_hex());
      end
    endcase
  endtask

  // Mostly well-formed escaped strings; the rest carry a bad escape, a bad hex
  // digit, an escape cut off by the string end, or plain noise.
  task automatic build_decode_text();
    int         roll;
    logic [7:0] c;
    logic [4:0] hv;
    text.delete();
    roll = $urandom_range(99);
    if (roll < 75) begin
      repeat ($urandom_range(1, 6)) push_token();
    end else if (roll < 96) begin
      repeat ($urandom_range(0, 2)) push_token();
      text.push_back(CH_BSLASH);
      if (roll < 84) begin
        do c = 8'($urandom_range(255));
        while (c == CH_BSLASH || c == CH_N || c == CH_R || c == CH_T || c == CH_X);
        text.push_back(c);
      end else if (roll < 91) begin
        text.push_back(CH_X);
        if ($urandom_range(1)) text.push_back(rand_hex());
        do begin
          c = 8'($urandom_range(255));
          hv = nib_value(c);
        end while (!hv[4]);
        text.push_back(c);
      end else begin
        roll = $urandom_range(2);
        if (roll > 0) text.push_back(CH_X);
        if (roll > 1) text.push_back(rand_hex());
        roll = 100;
      end
      if (roll < 91) repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic build_encode_text();
    text.delete();
    repeat ($urandom_range(1, 6))
      text.push_back($urandom_range(99) < 60 ? 8'($urandom_range(255))
                                              : ENC_EDGE[$urandom_range(8)]);
  endtask

  initial begin
    int row;
    int pass;
    int start;
    int dk;
    logic d;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (row = 0; row < $size(PLAN); row++) begin
      if (PLAN[row].mode != cur_mode) set_direction(PLAN[row].mode);
      send_byte(PLAN[row].b, PLAN[row].fin, PLAN[row].kind, PLAN[row].n, PLAN[row].bytes);
    end

    for (pass = 0; pass < 3; pass++) begin
      send_idle_pct = (pass == 0) ? 33 : (pass == 1) ? 73 : 0;
      stall_pct = (pass == 0) ? 73 : (pass == 1) ? 33 : 0;
      for (dk = 0; dk < 2; dk++) begin
        d = (dk == 0) ? DIR_ENCODE : DIR_DECODE;
        set_direction(d);
        start = sent_bytes;
        while (sent_bytes < start + CHUNK_BYTES) begin
          if (d == DIR_ENCODE) build_encode_text();
          else build_decode_text();
          send_text();
        end
      end
    end

    wait_quiet();
    $display("Sent %0d bytes in encode and decode mode over %0d direction writes,",
             sent_bytes, cfg_writes);
    $display("with sender and receiver idling in turn; %0d results checked.", results_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
